### sv/bts_pkg.sv
`default_nettype none

package bts_pkg;

   localparam int unsigned QUEUE_DEPTH_DEF = 8;
   localparam int unsigned SIGNAL_COUNT    = 6;
   localparam int unsigned CSR_INDEX_W     = 2;
   localparam int unsigned CSR_DATA_W      = 7;

   localparam logic [1:0] REQ_TICK   = 2'd0;
   localparam logic [1:0] REQ_PLAY   = 2'd1;
   localparam logic [1:0] REQ_CANCEL = 2'd2;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   localparam logic [2:0] KIND_TICK   = 3'd0;
   localparam logic [2:0] KIND_PLAY   = 3'd1;
   localparam logic [2:0] KIND_BAD    = 3'd2;
   localparam logic [2:0] KIND_CANCEL = 3'd3;
   localparam logic [2:0] KIND_NOP    = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLED = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VOLUME  = 2'd1;

   typedef struct packed {
      logic [1:0] req_type;
      logic [2:0] signal_id;
   } bts_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        tone_on;
      logic [11:0] tone_freq_hz;
      logic [6:0]  tone_volume;
      logic        busy_res;
      logic [3:0]  queue_count;
   } bts_rsp_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [2:0] signal_id;
   } bts_item_type;

   function automatic logic [1:0] note_total(input logic [2:0] pat);
      logic [1:0] n;
      unique case (pat)
         3'd0:    n = 2'd1;
         3'd1:    n = 2'd2;
         3'd2:    n = 2'd2;
         3'd3:    n = 2'd3;
         3'd4:    n = 2'd3;
         3'd5:    n = 2'd3;
         default: n = 2'd0;
      endcase
      return n;
   endfunction

   function automatic logic [11:0] note_freq(input logic [2:0] pat, input logic [1:0] idx);
      logic [11:0] f;
      unique case ({pat, idx})
         {3'd0, 2'd0}: f = 12'd2400;
         {3'd1, 2'd0}: f = 12'd1800;
         {3'd1, 2'd1}: f = 12'd2600;
         {3'd2, 2'd0}: f = 12'd1400;
         {3'd2, 2'd1}: f = 12'd1400;
         {3'd3, 2'd0}: f = 12'd700;
         {3'd3, 2'd1}: f = 12'd700;
         {3'd3, 2'd2}: f = 12'd700;
         {3'd4, 2'd0}: f = 12'd1200;
         {3'd4, 2'd1}: f = 12'd1800;
         {3'd4, 2'd2}: f = 12'd2600;
         {3'd5, 2'd0}: f = 12'd2400;
         {3'd5, 2'd1}: f = 12'd1600;
         {3'd5, 2'd2}: f = 12'd900;
         default:      f = 12'd0;
      endcase
      return f;
   endfunction

   function automatic logic [7:0] note_len(input logic [2:0] pat, input logic [1:0] idx);
      logic [7:0] l;
      unique case ({pat, idx})
         {3'd0, 2'd0}: l = 8'd50;
         {3'd1, 2'd0}: l = 8'd80;
         {3'd1, 2'd1}: l = 8'd120;
         {3'd2, 2'd0}: l = 8'd140;
         {3'd2, 2'd1}: l = 8'd140;
         {3'd3, 2'd0}: l = 8'd160;
         {3'd3, 2'd1}: l = 8'd160;
         {3'd3, 2'd2}: l = 8'd220;
         {3'd4, 2'd0}: l = 8'd70;
         {3'd4, 2'd1}: l = 8'd70;
         {3'd4, 2'd2}: l = 8'd120;
         {3'd5, 2'd0}: l = 8'd80;
         {3'd5, 2'd1}: l = 8'd80;
         {3'd5, 2'd2}: l = 8'd150;
         default:      l = 8'd0;
      endcase
      return l;
   endfunction

   function automatic logic [7:0] note_gap(input logic [2:0] pat, input logic [1:0] idx);
      logic [7:0] g;
      unique case ({pat, idx})
         {3'd1, 2'd0}: g = 8'd40;
         {3'd2, 2'd0}: g = 8'd100;
         {3'd3, 2'd0}: g = 8'd80;
         {3'd3, 2'd1}: g = 8'd80;
         {3'd4, 2'd0}: g = 8'd30;
         {3'd4, 2'd1}: g = 8'd30;
         {3'd5, 2'd0}: g = 8'd40;
         {3'd5, 2'd1}: g = 8'd40;
         default:      g = 8'd0;
      endcase
      return g;
   endfunction

endpackage

`default_nettype wire

### sv/bts_ram.sv
`default_nettype none

module bts_ram #(
   parameter int unsigned WIDTH = 3,
   parameter int unsigned DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/bts_front.sv
`default_nettype none

module bts_front
   import bts_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output      logic         req_stall,
   input  wire bts_req_type  req_data,
   output      logic         item_valid,
   input  wire logic         item_pop,
   output      bts_item_type item
);

   bts_item_type q_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   bts_item_type classified;
   logic         push;
   logic         pop;

   always_comb begin
      classified.signal_id = req_data.signal_id;
      unique case (req_data.req_type)
         REQ_TICK:   classified.kind = KIND_TICK;
         REQ_PLAY:   classified.kind = (req_data.signal_id >= 3'(SIGNAL_COUNT)) ?
                                       KIND_BAD : KIND_PLAY;
         REQ_CANCEL: classified.kind = KIND_CANCEL;
         REQ_UNUSED: classified.kind = KIND_NOP;
         default:    classified.kind = KIND_NOP;
      endcase
   end

   assign req_stall  = (count_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign pop        = item_pop && item_valid;
   assign item_valid = (count_ff != 2'd0);
   assign item       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

`default_nettype wire

### sv/bts_back.sv
`default_nettype none

module bts_back
   import bts_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   item_valid,
   output      logic                   item_pop,
   input  wire bts_item_type           item,
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      bts_rsp_type            rsp_data
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_TONE  = 2'd1;
   localparam logic [1:0] PH_PAUSE = 2'd2;

   logic              enabled_ff, enabled_in;
   logic [6:0]        volume_ff, volume_in;
   logic [PTR_W-1:0]  rptr_ff, rptr_in;
   logic [PTR_W-1:0]  wptr_ff, wptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [1:0]        phase_ff, phase_in;
   logic [2:0]        pattern_ff, pattern_in;
   logic [1:0]        note_ff, note_in;
   logic [7:0]        rem_ff, rem_in;
   logic [6:0]        lvol_ff, lvol_in;
   logic              bypass_valid_ff, bypass_valid_in;
   logic [2:0]        bypass_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   bts_rsp_type       rsp_ff, rsp_in;

   logic              item_go;
   logic              pop_req;
   logic              wr_en;
   logic [2:0]        ram_rd_data;
   logic [2:0]        head_sig;
   logic [7:0]        rem_dec;
   logic [1:0]        next_note;
   logic [1:0]        status;
   logic [CNT_W+3:0]  count_wide;

   // a register write takes the cycle; the waiting item stays until no register write is taken
   assign item_go  = item_valid && !csr_write && (!rsp_valid_ff || !rsp_stall);
   assign item_pop = item_go;
   assign head_sig = bypass_valid_ff ? bypass_data_ff : ram_rd_data;

   bts_ram #(
      .WIDTH (3),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wptr_ff),
      .wr_data (item.signal_id),
      .rd_addr (rptr_in),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      enabled_in = enabled_ff;
      volume_in  = volume_ff;
      rptr_in    = rptr_ff;
      wptr_in    = wptr_ff;
      count_in   = count_ff;
      phase_in   = phase_ff;
      pattern_in = pattern_ff;
      note_in    = note_ff;
      rem_in     = rem_ff;
      lvol_in    = lvol_ff;
      status     = ST_OK;
      pop_req    = 1'b0;
      wr_en      = 1'b0;
      rem_dec    = (rem_ff != 8'd0) ? rem_ff - 8'd1 : 8'd0;
      next_note  = note_ff + 2'd1;

      if (csr_write) begin
         if (csr_index == CSR_ENABLED) begin
            enabled_in = csr_data[0];
            if (!csr_data[0]) begin
               rptr_in  = '0;
               wptr_in  = '0;
               count_in = '0;
               phase_in = PH_IDLE;
               rem_in   = 8'd0;
            end
         end else if (csr_index == CSR_VOLUME) begin
            if (csr_data <= 7'd100) begin
               volume_in = csr_data;
               if (csr_data == 7'd0) begin
                  rptr_in  = '0;
                  wptr_in  = '0;
                  count_in = '0;
                  phase_in = PH_IDLE;
                  rem_in   = 8'd0;
               end
            end
         end
      end else if (item_go) begin
         unique case (item.kind)
            KIND_TICK: begin
               if (phase_ff == PH_IDLE) begin
                  pop_req = 1'b1;
               end else begin
                  rem_in = rem_dec;
                  if (rem_dec == 8'd0) begin
                     if (phase_ff == PH_TONE && note_gap(pattern_ff, note_ff) != 8'd0) begin
                        phase_in = PH_PAUSE;
                        rem_in   = note_gap(pattern_ff, note_ff);
                     end else begin
                        note_in = next_note;
                        if (next_note < note_total(pattern_ff) && enabled_ff) begin
                           lvol_in  = volume_ff;
                           phase_in = PH_TONE;
                           rem_in   = note_len(pattern_ff, next_note);
                        end else begin
                           phase_in = PH_IDLE;
                           rem_in   = 8'd0;
                           pop_req  = 1'b1;
                        end
                     end
                  end
               end
            end
            KIND_PLAY: begin
               if (enabled_ff) begin
                  if (count_ff >= CNT_W'(QUEUE_DEPTH)) begin
                     status = ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wptr_in  = (wptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                                wptr_ff + PTR_W'(1);
                     count_in = count_ff + CNT_W'(1);
                  end
               end
            end
            KIND_BAD: begin
               status = ST_INVALID;
            end
            KIND_CANCEL: begin
               rptr_in  = '0;
               wptr_in  = '0;
               count_in = '0;
               phase_in = PH_IDLE;
               rem_in   = 8'd0;
            end
            default: begin
            end
         endcase

         if (pop_req && count_ff != '0) begin
            rptr_in  = (rptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + PTR_W'(1);
            count_in = count_ff - CNT_W'(1);
            if (enabled_ff) begin
               pattern_in = head_sig;
               note_in    = 2'd0;
               lvol_in    = volume_ff;
               phase_in   = PH_TONE;
               rem_in     = note_len(head_sig, 2'd0);
            end
         end
      end

      bypass_valid_in = wr_en && (wptr_ff == rptr_in);

      count_wide          = {4'd0, count_in};
      rsp_in.status       = status;
      rsp_in.tone_on      = (phase_in == PH_TONE);
      rsp_in.tone_freq_hz = (phase_in == PH_TONE) ? note_freq(pattern_in, note_in) : 12'd0;
      rsp_in.tone_volume  = lvol_in;
      rsp_in.busy_res     = (phase_in != PH_IDLE);
      rsp_in.queue_count  = count_wide[3:0];

      if (item_go) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff      <= 1'b1;
         volume_ff       <= 7'd50;
         rptr_ff         <= '0;
         wptr_ff         <= '0;
         count_ff        <= '0;
         phase_ff        <= PH_IDLE;
         pattern_ff      <= 3'd0;
         note_ff         <= 2'd0;
         rem_ff          <= 8'd0;
         lvol_ff         <= 7'd0;
         bypass_valid_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         enabled_ff      <= enabled_in;
         volume_ff       <= volume_in;
         rptr_ff         <= rptr_in;
         wptr_ff         <= wptr_in;
         count_ff        <= count_in;
         phase_ff        <= phase_in;
         pattern_ff      <= pattern_in;
         note_ff         <= note_in;
         rem_ff          <= rem_in;
         lvol_ff         <= lvol_in;
         bypass_valid_ff <= bypass_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bypass_data_ff <= item.signal_id;
      if (item_go) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("request queue count above depth");

   a_active_timer: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_TONE || phase_ff == PH_PAUSE) |-> rem_ff != 8'd0)
      else $error("active phase with expired timer");

   a_idle_timer: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> rem_ff == 8'd0)
      else $error("idle phase with running timer");

   a_note_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_TONE |-> note_ff < note_total(pattern_ff))
      else $error("tone on a note beyond the pattern");

   a_cancel_flush: assert property (@(posedge clock) disable iff (reset)
      (item_go && !csr_write && item.kind == KIND_CANCEL) |=>
         (count_ff == '0 && phase_ff == PH_IDLE))
      else $error("cancel left queued or active work");

endmodule

`default_nettype wire

### sv/buzzer_tone_pattern_sequencer_top.sv
// A result passes through the front queue, then the result register, which presents it.
// Throughput: one input item per cycle while no configuration write or result stall holds
// the back end; the front queue and the result register decouple stalls.
// Configuration writes are taken in any cycle (ready held high); no item is taken in that cycle.
// Reset (synchronous, active high): enabled 1, volume 50, queue empty, sequencer idle;
// queue RAM contents are not cleared and no clearing pass follows reset.
`default_nettype none

module buzzer_tone_pattern_sequencer_top
   import bts_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire bts_req_type            req_data,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      bts_rsp_type            rsp_data,
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   logic         item_valid;
   logic         item_pop;
   bts_item_type item;

   assign csr_ready = 1'b1;

   bts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item       (item)
   );

   bts_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item       (item),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

### verif/buzzer_tone_pattern_sequencer_top_test.sv
`default_nettype none

module buzzer_tone_pattern_sequencer_top_test;
   import bts_pkg::*;

   localparam int unsigned VOLUME_MAX   = 100;

   typedef enum logic [1:0] {SEQ_IDLE, SEQ_TONE, SEQ_PAUSE} seq_phase_type;
   typedef enum int {PACE_NONE, PACE_FULL, PACE_SPARSE} pace_type;

   typedef struct packed {
      logic [11:0] hz;
      logic [7:0]  ms;
      logic [7:0]  gap;
   } tone_note_type;

   class buzzer_scoreboard;
      bit            enabled;
      logic [6:0]    volume;
      logic [2:0]    fifo_mem [QUEUE_DEPTH_DEF];
      int unsigned   rd_ptr;
      int unsigned   wr_ptr;
      int unsigned   fifo_cnt;
      seq_phase_type phase;
      logic [2:0]    pattern;
      logic [1:0]    note;
      logic [7:0]    remain_ms;
      logic [6:0]    held_volume;
      bts_rsp_type   expected_tones[$];
      int            mismatches;
      int            results_seen;

      function new();
         enabled      = 1'b1;
         volume       = 7'd50;
         pattern      = '0;
         note         = '0;
         held_volume  = '0;
         mismatches   = 0;
         results_seen = 0;
         flush();
      endfunction

      function tone_note_type note_rom(logic [2:0] pat, logic [1:0] idx);
         case ({pat, idx})
            {3'd0, 2'd0}: return {12'd2400, 8'd50, 8'd0};
            {3'd1, 2'd0}: return {12'd1800, 8'd80, 8'd40};
            {3'd1, 2'd1}: return {12'd2600, 8'd120, 8'd0};
            {3'd2, 2'd0}: return {12'd1400, 8'd140, 8'd100};
            {3'd2, 2'd1}: return {12'd1400, 8'd140, 8'd0};
            {3'd3, 2'd0}: return {12'd700, 8'd160, 8'd80};
            {3'd3, 2'd1}: return {12'd700, 8'd160, 8'd80};
            {3'd3, 2'd2}: return {12'd700, 8'd220, 8'd0};
            {3'd4, 2'd0}: return {12'd1200, 8'd70, 8'd30};
            {3'd4, 2'd1}: return {12'd1800, 8'd70, 8'd30};
            {3'd4, 2'd2}: return {12'd2600, 8'd120, 8'd0};
            {3'd5, 2'd0}: return {12'd2400, 8'd80, 8'd40};
            {3'd5, 2'd1}: return {12'd1600, 8'd80, 8'd40};
            {3'd5, 2'd2}: return {12'd900, 8'd150, 8'd0};
            default:      return '0;
         endcase
      endfunction

      function int notes_in(logic [2:0] pat);
         case (pat)
            3'd0:             return 1;
            3'd1, 3'd2:       return 2;
            3'd3, 3'd4, 3'd5: return 3;
            default:          return 0;
         endcase
      endfunction

      function void flush();
         rd_ptr    = 0;
         wr_ptr    = 0;
         fifo_cnt  = 0;
         phase     = SEQ_IDLE;
         remain_ms = '0;
      endfunction

      function void start_note();
         tone_note_type n;
         n           = note_rom(pattern, note);
         held_volume = volume;
         phase       = SEQ_TONE;
         remain_ms   = n.ms;
      endfunction

      function void pop_next();
         logic [2:0] sig;
         if (fifo_cnt == 0)
            return;
         sig      = fifo_mem[rd_ptr];
         rd_ptr   = (rd_ptr + 1) % QUEUE_DEPTH_DEF;
         fifo_cnt = fifo_cnt - 1;
         if (!enabled || sig >= SIGNAL_COUNT)
            return;
         pattern = sig;
         note    = '0;
         start_note();
      endfunction

      function void next_note();
         note = note + 2'd1;
         if (note < notes_in(pattern) && enabled) begin
            start_note();
         end else begin
            phase     = SEQ_IDLE;
            remain_ms = '0;
            pop_next();
         end
      endfunction

      function void tick();
         tone_note_type n;
         if (phase == SEQ_IDLE) begin
            pop_next();
            return;
         end
         if (remain_ms > 0)
            remain_ms = remain_ms - 8'd1;
         if (remain_ms != 0)
            return;
         n = note_rom(pattern, note);
         if (phase == SEQ_TONE && n.gap > 0) begin
            phase     = SEQ_PAUSE;
            remain_ms = n.gap;
         end else begin
            next_note();
         end
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         if (idx == CSR_ENABLED) begin
            enabled = val[0];
            if (!enabled)
               flush();
         end else if (idx == CSR_VOLUME && val <= VOLUME_MAX) begin
            volume = val;
            if (val == 0)
               flush();
         end
      endfunction

      function void predict_tone(bts_req_type item);
         bts_rsp_type   r;
         tone_note_type n;
         r        = '0;
         r.status = ST_OK;
         case (item.req_type)
            REQ_TICK: tick();
            REQ_PLAY: begin
               if (item.signal_id >= SIGNAL_COUNT) begin
                  r.status = ST_INVALID;
               end else if (enabled) begin
                  if (fifo_cnt >= QUEUE_DEPTH_DEF) begin
                     r.status = ST_FULL;
                  end else begin
                     fifo_mem[wr_ptr] = item.signal_id;
                     wr_ptr           = (wr_ptr + 1) % QUEUE_DEPTH_DEF;
                     fifo_cnt         = fifo_cnt + 1;
                  end
               end
            end
            REQ_CANCEL: flush();
            default: ;
         endcase
         n              = note_rom(pattern, note);
         r.tone_on      = (phase == SEQ_TONE);
         r.tone_freq_hz = (phase == SEQ_TONE) ? n.hz : 12'd0;
         r.tone_volume  = held_volume;
         r.busy_res     = (phase != SEQ_IDLE);
         r.queue_count  = 4'(fifo_cnt);
         expected_tones.push_back(r);
      endfunction

      task report(string msg);
         mismatches++;
         $display("MISMATCH: %s", msg);
      endtask

      task compare_field(string name, logic [11:0] got, logic [11:0] want);
         if (got !== want)
            report($sformatf("result %0d %s: got %0d expected %0d",
                             results_seen, name, got, want));
      endtask

      task check_tone(bts_rsp_type got);
         bts_rsp_type want;
         results_seen++;
         if (expected_tones.size() == 0) begin
            report($sformatf("result %0d arrived with nothing expected", results_seen));
            return;
         end
         want = expected_tones.pop_front();
         compare_field("status", 12'(got.status), 12'(want.status));
         compare_field("tone_on", 12'(got.tone_on), 12'(want.tone_on));
         compare_field("tone_freq_hz", got.tone_freq_hz, want.tone_freq_hz);
         compare_field("tone_volume", 12'(got.tone_volume), 12'(want.tone_volume));
         compare_field("busy_res", 12'(got.busy_res), 12'(want.busy_res));
         compare_field("queue_count", 12'(got.queue_count), 12'(want.queue_count));
      endtask

      function int pending();
         return expected_tones.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid;
   logic                   req_stall;
   bts_req_type            req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   bts_rsp_type            rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   buzzer_scoreboard tone_board;
   pace_type         req_pace = PACE_NONE;
   pace_type         rsp_pace = PACE_NONE;
   int               rsp_hold_cycles = 0;

   buzzer_tone_pattern_sequencer_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int draw_gap(pace_type pace);
      case (pace)
         PACE_NONE: return 0;
         PACE_FULL: return $urandom_range(0, 13);
         default:   return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 13) : 0;
      endcase
   endfunction

   function automatic bts_req_type make_req(logic [1:0] kind, logic [2:0] sig);
      bts_req_type r;
      r.req_type  = kind;
      r.signal_id = sig;
      return r;
   endfunction

   function automatic logic [2:0] pick_signal();
      return ($urandom_range(0, 1) == 0) ? 3'd0 : 3'($urandom_range(0, 5));
   endfunction

   function automatic bts_req_type next_random_req();
      int r;
      r = $urandom_range(0, 999);
      if (r < 930)
         return make_req(REQ_TICK, 3'($urandom_range(0, 7)));
      else if (r < 965)
         return make_req(REQ_PLAY, pick_signal());
      else if (r < 975)
         return make_req(REQ_PLAY, 3'($urandom_range(6, 7)));
      else if (r < 980)
         return make_req(REQ_CANCEL, 3'($urandom_range(0, 7)));
      else
         return make_req(REQ_UNUSED, 3'($urandom_range(0, 7)));
   endfunction

   // called and returns at a falling edge; valid stays up for back-to-back transfers
   task automatic send_item(bts_req_type item);
      int gap;
      gap = draw_gap(req_pace);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      do @(posedge clock); while (req_stall !== 1'b0);
      tone_board.predict_tone(item);
      @(negedge clock);
   endtask

   task automatic wait_drain();
      req_valid = 1'b0;
      while (tone_board.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      tone_board.write_reg(idx, val);
      @(negedge clock);
      csr_valid = 1'b0;
      repeat (2) @(negedge clock);
   endtask

   task automatic run_phase(int count, pace_type send_pace, pace_type take_pace);
      int sent;
      sent     = 0;
      req_pace = send_pace;
      rsp_pace = take_pace;
      while (sent < count) begin
         if ($urandom_range(0, 149) == 0) begin
            // enough plays in a row to overflow the queue
            repeat (QUEUE_DEPTH_DEF + 1) send_item(make_req(REQ_PLAY, pick_signal()));
            sent += QUEUE_DEPTH_DEF + 1;
         end else begin
            send_item(next_random_req());
            sent++;
         end
      end
      wait_drain();
   endtask

   initial begin : rsp_side
      int pause;
      pause     = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_stall = 1'b1;
         end else if (pause > 0) begin
            pause--;
            rsp_stall = 1'b1;
         end else begin
            rsp_stall = 1'b0;
         end
         @(posedge clock);
         if (reset === 1'b0 && rsp_valid === 1'b1 && !rsp_stall) begin
            tone_board.check_tone(rsp_data);
            pause = draw_gap(rsp_pace);
         end
      end
   end

   initial begin : watchdog
      #2000000;
      $display("buzzer_tone_pattern_sequencer_top test failed");
      $finish;
   end

   initial begin : stimulus
      tone_board = new();
      req_valid  = 1'b0;
      req_data   = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_ENABLED;
      csr_data   = '0;
      reset      = 1'b1;
      repeat (5) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed: bad ids, unused type, empty tick and cancel, queue overflow
      rsp_pace = PACE_FULL;
      send_item(make_req(REQ_PLAY, 3'd6));
      send_item(make_req(REQ_PLAY, 3'd7));
      send_item(make_req(REQ_UNUSED, 3'd7));
      send_item(make_req(REQ_TICK, 3'd0));
      send_item(make_req(REQ_CANCEL, 3'd0));
      for (int s = 0; s < SIGNAL_COUNT; s++)
         send_item(make_req(REQ_PLAY, 3'(s)));
      send_item(make_req(REQ_PLAY, 3'd0));
      send_item(make_req(REQ_PLAY, 3'd1));
      send_item(make_req(REQ_PLAY, 3'd2));
      send_item(make_req(REQ_TICK, 3'd0));
      send_item(make_req(REQ_TICK, 3'd0));
      send_item(make_req(REQ_CANCEL, 3'd5));
      send_item(make_req(REQ_TICK, 3'd0));
      send_item(make_req(REQ_PLAY, 3'd0));
      send_item(make_req(REQ_TICK, 3'd0));
      send_item(make_req(REQ_PLAY, 3'd3));
      send_item(make_req(REQ_TICK, 3'd0));
      wait_drain();

      // receiver holds off while the sender keeps offering
      req_pace        = PACE_NONE;
      rsp_hold_cycles = 150;
      repeat (40) send_item(next_random_req());
      wait_drain();

      run_phase(260, PACE_FULL, PACE_FULL);
      write_csr(CSR_VOLUME, 7'd100);
      run_phase(300, PACE_NONE, PACE_SPARSE);
      write_csr(CSR_VOLUME, 7'd127);
      write_csr(CSR_VOLUME, 7'd0);
      run_phase(260, PACE_SPARSE, PACE_FULL);
      write_csr(CSR_ENABLED, 7'h7E);
      run_phase(100, PACE_FULL, PACE_NONE);
      write_csr(CSR_ENABLED, 7'h01);
      write_csr(CSR_VOLUME, 7'd1);
      run_phase(280, PACE_NONE, PACE_NONE);
      write_csr(CSR_VOLUME, 7'($urandom_range(2, 99)));
      write_csr(CSR_ENABLED, {6'($urandom_range(0, 63)), 1'b1});
      run_phase(300, PACE_SPARSE, PACE_SPARSE);

      repeat (10) @(negedge clock);
      if (tone_board.mismatches == 0 && tone_board.pending() == 0)
         $display("buzzer_tone_pattern_sequencer_top test passed");
      else
         $display("buzzer_tone_pattern_sequencer_top test failed");
      $finish;
   end

endmodule

`default_nettype wire
